>>> rtl/owtp_pkg.sv
// Shared types and constants for the 1-Wire temperature poller.
`timescale 1ns / 1ps

package owtp_pkg;

  localparam int READ_BYTES = 2;
  localparam int BYTE_IDX_W = (READ_BYTES > 3) ? 4 : 2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_SMP  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_SLOT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_LOW     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_READ_SMP      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BIT_SLOT      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CONV_WAIT     = 3'd6;

  localparam logic [2:0] PH_RESET1  = 3'd0;
  localparam logic [2:0] PH_SKIP1   = 3'd1;
  localparam logic [2:0] PH_CONVERT = 3'd2;
  localparam logic [2:0] PH_WAIT    = 3'd3;
  localparam logic [2:0] PH_RESET2  = 3'd4;
  localparam logic [2:0] PH_SKIP2   = 3'd5;
  localparam logic [2:0] PH_READCMD = 3'd6;
  localparam logic [2:0] PH_READ    = 3'd7;

  localparam logic [1:0] PS_PRESENT = 2'd0;
  localparam logic [1:0] PS_ABSENT  = 2'd1;
  localparam logic [1:0] PS_SHORT   = 2'd2;

  localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
  localparam logic [7:0] CMD_CONVERT    = 8'h44;
  localparam logic [7:0] CMD_READ_SCRPD = 8'hBE;

  typedef struct packed {
    logic [9:0]  reset_low_ticks;
    logic [9:0]  presence_sample_tick;
    logic [9:0]  reset_slot_ticks;
    logic [9:0]  start_low_ticks;
    logic [9:0]  read_sample_tick;
    logic [9:0]  bit_slot_ticks;
    logic [23:0] conversion_wait_ticks;
  } owtp_cfg_t;

  typedef struct packed {
    logic [2:0]            phase;
    logic [9:0]            slot_counter;
    logic [2:0]            bit_index;
    logic [BYTE_IDX_W-1:0] byte_index;
    logic [15:0]           shift_word;
    logic [23:0]           wait_counter;
    logic                  presence_latch;
    logic [19:0]           last_temperature;
  } owtp_state_t;

  typedef struct packed {
    logic        drive_low;
    logic        reading_busy;
    logic        presence_valid;
    logic [1:0]  presence_status;
    logic        temp_valid;
    logic [15:0] temp_raw;
    logic [19:0] temp_tenths_q4;
  } owtp_result_t;

endpackage

>>> rtl/owtp_sequencer.sv
// Per-tick bus sequencer: next state and result of one tick.
`timescale 1ns / 1ps

module owtp_sequencer
  import owtp_pkg::*;
(
  input  owtp_state_t  state,
  input  owtp_cfg_t    cfg,
  input  logic         line_level,
  output owtp_state_t  state_next,
  output owtp_result_t result
);

  logic [2:0]  phase_adv;
  logic [9:0]  t;
  logic [10:0] t_inc;
  logic [9:0]  s_rst;
  logic [10:0] e_rst;
  logic [9:0]  s_rd;
  logic [10:0] e_rd;
  logic [9:0]  e_wr_a;
  logic [9:0]  e_wr;
  logic [24:0] wait_inc;
  logic [7:0]  cmd;

  assign t         = state.slot_counter;
  assign t_inc     = {1'b0, t} + 11'd1;
  assign phase_adv = (state.phase == PH_READ) ? PH_RESET1 : state.phase + 3'd1;

  assign s_rst = (cfg.reset_low_ticks > cfg.presence_sample_tick) ?
                 cfg.reset_low_ticks : cfg.presence_sample_tick;
  assign e_rst = (({1'b0, s_rst} + 11'd1) > {1'b0, cfg.reset_slot_ticks}) ?
                 ({1'b0, s_rst} + 11'd1) : {1'b0, cfg.reset_slot_ticks};

  assign s_rd = (cfg.start_low_ticks > cfg.read_sample_tick) ?
                cfg.start_low_ticks : cfg.read_sample_tick;
  assign e_rd = (({1'b0, s_rd} + 11'd1) > {1'b0, cfg.bit_slot_ticks}) ?
                ({1'b0, s_rd} + 11'd1) : {1'b0, cfg.bit_slot_ticks};

  assign e_wr_a = (cfg.start_low_ticks > cfg.bit_slot_ticks) ?
                  cfg.start_low_ticks : cfg.bit_slot_ticks;
  assign e_wr   = (e_wr_a == 10'd0) ? 10'd1 : e_wr_a;

  assign wait_inc = {1'b0, state.wait_counter} + 25'd1;

  always_comb begin
    unique case (state.phase)
      PH_SKIP1, PH_SKIP2: cmd = CMD_SKIP_ROM;
      PH_CONVERT:         cmd = CMD_CONVERT;
      default:            cmd = CMD_READ_SCRPD;
    endcase
  end

  always_comb begin
    logic                  advance;
    logic [BYTE_IDX_W-1:0] byte_inc;
    logic signed [19:0]    raw_ext;
    logic [3:0]            bit_pos;

    state_next = state;
    result     = '0;
    advance    = 1'b0;
    byte_inc   = state.byte_index + BYTE_IDX_W'(1);
    raw_ext    = '0;
    bit_pos    = {state.byte_index[0], state.bit_index};

    unique case (state.phase)
      PH_RESET1, PH_RESET2: begin
        if (t == 10'd0 && !line_level) begin
          // bus held low before we drive: shorted
          result.presence_valid  = 1'b1;
          result.presence_status = PS_SHORT;
          advance = 1'b1;
        end else begin
          result.drive_low = (t < cfg.reset_low_ticks);
          if (t == s_rst) state_next.presence_latch = line_level;
          if (t_inc >= e_rst) begin
            result.presence_valid  = 1'b1;
            result.presence_status = state_next.presence_latch ? PS_ABSENT : PS_PRESENT;
            advance = 1'b1;
          end else begin
            state_next.slot_counter = t_inc[9:0];
          end
        end
      end
      PH_WAIT: begin
        if (wait_inc >= {1'b0, cfg.conversion_wait_ticks}) begin
          state_next.wait_counter = '0;
          advance = 1'b1;
        end else begin
          state_next.wait_counter = wait_inc[23:0];
        end
      end
      PH_READ: begin
        result.reading_busy = 1'b1;
        result.drive_low    = (t < cfg.start_low_ticks);
        if (t == s_rd && {2'b00, state.byte_index} < 4'd2)
          state_next.shift_word[bit_pos] = line_level;
        if (t_inc >= e_rd) begin
          state_next.slot_counter = '0;
          state_next.bit_index    = state.bit_index + 3'd1;
          if (state.bit_index == 3'd7) begin
            if ({{(8-BYTE_IDX_W){1'b0}}, byte_inc} >= 8'(READ_BYTES)) begin
              raw_ext = {{4{state_next.shift_word[15]}}, state_next.shift_word};
              state_next.last_temperature = (raw_ext <<< 3) + (raw_ext <<< 1);
              result.temp_valid = 1'b1;
              result.temp_raw   = state_next.shift_word;
              state_next.byte_index = '0;
              advance = 1'b1;
            end else begin
              state_next.byte_index = byte_inc;
            end
          end
        end else begin
          state_next.slot_counter = t_inc[9:0];
        end
      end
      default: begin
        result.drive_low = (t < cfg.start_low_ticks) || !cmd[state.bit_index];
        if (t_inc >= {1'b0, e_wr}) begin
          state_next.slot_counter = '0;
          state_next.bit_index    = state.bit_index + 3'd1;
          if (state.bit_index == 3'd7) advance = 1'b1;
        end else begin
          state_next.slot_counter = t_inc[9:0];
        end
      end
    endcase

    if (advance) begin
      state_next.slot_counter = '0;
      state_next.phase        = phase_adv;
      if (phase_adv == PH_READ) begin
        state_next.shift_word = '0;
        state_next.byte_index = '0;
      end
    end

    result.temp_tenths_q4 = state_next.last_temperature;
  end

endmodule

>>> rtl/one_wire_temperature_poller_core.sv
// Top level of the 1-Wire temperature poller: registers, config and output stage.
`timescale 1ns / 1ps

// Each input beat is one bus tick with the sampled line level; each accepted beat
// yields exactly one result beat, one tick per clock cycle when both sides keep
// up. The sequencer step is a single pass of logic from the state registers into
// a one-deep output register, and ready stays high while that register is empty
// or being taken, so a new tick is taken in the same cycle as the waiting result
// leaves; while a result is held back, ready is low. The block loops forever:
// reset/presence, skip-ROM, convert, conversion wait, reset/presence, skip-ROM,
// read scratchpad, then reads the result bytes LSB first. The user must write
// timing registers via the cfg port only while no tick is in flight (unchecked).

module one_wire_temperature_poller_core
  import owtp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   line_level,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   drive_low,
  output logic                   reading_busy,
  output logic                   presence_valid,
  output logic [1:0]             presence_status,
  output logic                   temp_valid,
  output logic signed [15:0]     temp_raw,
  output logic signed [19:0]     temp_tenths_q4
);

  owtp_cfg_t    cfg;
  owtp_state_t  state;
  owtp_state_t  state_next;
  owtp_result_t step_result;
  owtp_result_t result;
  logic         accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  owtp_sequencer u_sequencer (
    .state      (state),
    .cfg        (cfg),
    .line_level (line_level),
    .state_next (state_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks       <= 10'd480;
      cfg.presence_sample_tick  <= 10'd550;
      cfg.reset_slot_ticks      <= 10'd960;
      cfg.start_low_ticks       <= 10'd2;
      cfg.read_sample_tick      <= 10'd15;
      cfg.bit_slot_ticks        <= 10'd60;
      cfg.conversion_wait_ticks <= 24'd1000000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_LOW:    cfg.reset_low_ticks       <= cfg_data[9:0];
        REG_PRESENCE_SMP: cfg.presence_sample_tick  <= cfg_data[9:0];
        REG_RESET_SLOT:   cfg.reset_slot_ticks      <= cfg_data[9:0];
        REG_START_LOW:    cfg.start_low_ticks       <= cfg_data[9:0];
        REG_READ_SMP:     cfg.read_sample_tick      <= cfg_data[9:0];
        REG_BIT_SLOT:     cfg.bit_slot_ticks        <= cfg_data[9:0];
        REG_CONV_WAIT:    cfg.conversion_wait_ticks <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) result <= step_result;
  end

  assign drive_low       = result.drive_low;
  assign reading_busy    = result.reading_busy;
  assign presence_valid  = result.presence_valid;
  assign presence_status = result.presence_status;
  assign temp_valid      = result.temp_valid;
  assign temp_raw        = result.temp_raw;
  assign temp_tenths_q4  = result.temp_tenths_q4;

endmodule
